### rtl/abod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abod_pkg;

    localparam int OFFSET_WIDTH    = 16;
    localparam int PRIOR_W         = 17;
    localparam int VAR_W           = 16;
    localparam int SCALE_W         = 13;
    localparam int CFG_DATA_W      = 16;
    localparam int OUT_W           = 21;

    // table depth must be a power of two
    localparam int EXP_TABLE_DEPTH = 64;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_W           = 36;

    localparam int NUM_STAGES      = 6;

    // center path widths
    localparam int CT_W = OFFSET_WIDTH + VAR_W;
    localparam int CP_W = CT_W - 8 + PRIOR_W + 1;
    localparam int CS_W = CP_W - 16;
    localparam int C_W  = ((CS_W > 22) ? CS_W : 22) + 1;

    // size path widths
    localparam int A_W    = ((OFFSET_WIDTH + VAR_W + 1) > 33) ? (OFFSET_WIDTH + VAR_W + 1) : 33;
    localparam int HP_W   = PRIOR_W + EXP_W;
    localparam int HALF_W = 32;

    // corner path widths
    localparam int K_W = ((C_W > HALF_W + 1) ? C_W : HALF_W + 1) + 1;
    localparam int Q_W = K_W + SCALE_W + 1 - 16;

    localparam logic signed [A_W-1:0] EXP_ARG_HI = A_W'(32'h7FFF_FFFF);
    localparam logic signed [A_W-1:0] EXP_ARG_LO = ~EXP_ARG_HI;

    localparam logic signed [Q_W-1:0] OUT_MAX = Q_W'(21'h0F_FFFF);
    localparam logic signed [Q_W-1:0] OUT_MIN = ~OUT_MAX;

    localparam logic [VAR_W-1:0]   CENTER_VAR_RESET  = VAR_W'(6554);
    localparam logic [VAR_W-1:0]   SIZE_VAR_RESET    = VAR_W'(13107);
    localparam logic [SCALE_W-1:0] IMAGE_SCALE_RESET = SCALE_W'(416);

    typedef enum logic [1:0] {
        CFG_CENTER_VAR  = 2'd0,
        CFG_SIZE_VAR    = 2'd1,
        CFG_IMAGE_SCALE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [VAR_W-1:0]   center_var;
        logic [VAR_W-1:0]   size_var;
        logic [SCALE_W-1:0] image_scale;
    } cfg_t;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    typedef logic [EXP_TABLE_DEPTH-1:0][EXP_W-1:0] exp_table_t;

    localparam logic [63:0] QONE     = 64'd1 << 24;
    localparam logic [63:0] EXP_STEP = (64'd16 << 24) / EXP_TABLE_DEPTH;

    // restoring long division, used only while building the constant table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (QONE >> 1)) >> 24;
    endfunction

    function automatic logic [63:0] taylor_exp(input logic [63:0] y);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = QONE;
        term = QONE;
        for (int n = 1; n <= 30; n++) begin
            term = udiv64((term * y) >> 24, 64'(n));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Q12.24 exp over [-8, 8)
    function automatic exp_table_t build_exp_table();
        logic [63:0] e1;
        logic [63:0] e2;
        logic [63:0] e4;
        logic [63:0] e8;
        logic [63:0] r;
        logic [63:0] cur;
        exp_table_t  tab;
        e1  = taylor_exp(QONE);
        e2  = qmul(e1, e1);
        e4  = qmul(e2, e2);
        e8  = qmul(e4, e4);
        r   = taylor_exp(EXP_STEP);
        cur = udiv64((64'd1 << 48) + (e8 >> 1), e8);
        tab[0] = cur[EXP_W-1:0];
        for (int k = 1; k < EXP_TABLE_DEPTH; k++) begin
            cur    = qmul(cur, r);
            tab[k] = cur[EXP_W-1:0];
        end
        return tab;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

`default_nettype wire

### rtl/anchor_box_offset_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// SSD center-size prior box decoder. Each input item (four Q4.12 offsets and
// a Q1.16 prior box) yields one item with the Q16.4 pixel corners
// left/top/right/bottom, saturated. The datapath is a six-stage pipeline:
// one item per cycle sustained while m_tready is high, m_tvalid rises when
// the item reaches the last stage register, and a stall on m_tready backs
// up stage by stage without losing items. The exp
// of the size offset comes from a 64-entry constant table over [-8, 8).
// Registers are written on the cfg channel (0 center variance, 1 size
// variance, 2 image scale) and should only change while no item is in flight.

module anchor_box_offset_decoder_core
    import abod_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // offset_cx, offset_cy, offset_w, offset_h, prior_cx, prior_cy, prior_w,
    // prior_h, zero pad
    input  wire logic [135:0]          s_tdata,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // left_x, top_y, right_x, bottom_y, zero pad
    output logic [87:0]                m_tdata,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PB = 4 * OFFSET_WIDTH;

    cfg_t      cfg;
    stage_en_t en;
    stage_en_t valid_reg;
    stage_en_t valid_next;

    logic signed [C_W-1:0] cx;
    logic signed [C_W-1:0] cy;
    logic [HALF_W-1:0]     hw;
    logic [HALF_W-1:0]     hh;
    logic [OUT_W-1:0]      left_x;
    logic [OUT_W-1:0]      top_y;
    logic [OUT_W-1:0]      right_x;
    logic [OUT_W-1:0]      bottom_y;

    logic signed [OFFSET_WIDTH-1:0] offset_cx;
    logic signed [OFFSET_WIDTH-1:0] offset_cy;
    logic signed [OFFSET_WIDTH-1:0] offset_w;
    logic signed [OFFSET_WIDTH-1:0] offset_h;
    logic [PRIOR_W-1:0]             prior_cx;
    logic [PRIOR_W-1:0]             prior_cy;
    logic [PRIOR_W-1:0]             prior_w;
    logic [PRIOR_W-1:0]             prior_h;

    assign offset_cx = s_tdata[0*OFFSET_WIDTH +: OFFSET_WIDTH];
    assign offset_cy = s_tdata[1*OFFSET_WIDTH +: OFFSET_WIDTH];
    assign offset_w  = s_tdata[2*OFFSET_WIDTH +: OFFSET_WIDTH];
    assign offset_h  = s_tdata[3*OFFSET_WIDTH +: OFFSET_WIDTH];
    assign prior_cx  = s_tdata[PB + 0*PRIOR_W +: PRIOR_W];
    assign prior_cy  = s_tdata[PB + 1*PRIOR_W +: PRIOR_W];
    assign prior_w   = s_tdata[PB + 2*PRIOR_W +: PRIOR_W];
    assign prior_h   = s_tdata[PB + 3*PRIOR_W +: PRIOR_W];

    // stage i loads when empty or when the stage after it moves
    always_comb begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (en[i]) begin
                valid_next[i] = (i == 0) ? s_tvalid : valid_reg[(i == 0) ? 0 : i - 1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready  = en[0];
    assign m_tvalid  = valid_reg[NUM_STAGES-1];
    assign cfg_ready = 1'b1;

    abod_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    abod_center u_center_x (
        .aclk       (aclk),
        .en         (en),
        .offset     (offset_cx),
        .prior_c    (prior_cx),
        .prior_s    (prior_w),
        .center_var (cfg.center_var),
        .center     (cx)
    );

    abod_center u_center_y (
        .aclk       (aclk),
        .en         (en),
        .offset     (offset_cy),
        .prior_c    (prior_cy),
        .prior_s    (prior_h),
        .center_var (cfg.center_var),
        .center     (cy)
    );

    abod_half u_half_w (
        .aclk     (aclk),
        .en       (en),
        .offset   (offset_w),
        .prior_s  (prior_w),
        .size_var (cfg.size_var),
        .half     (hw)
    );

    abod_half u_half_h (
        .aclk     (aclk),
        .en       (en),
        .offset   (offset_h),
        .prior_s  (prior_h),
        .size_var (cfg.size_var),
        .half     (hh)
    );

    abod_corner u_corner_x (
        .aclk        (aclk),
        .en          (en),
        .center      (cx),
        .half        (hw),
        .image_scale (cfg.image_scale),
        .lo          (left_x),
        .hi          (right_x)
    );

    abod_corner u_corner_y (
        .aclk        (aclk),
        .en          (en),
        .center      (cy),
        .half        (hh),
        .image_scale (cfg.image_scale),
        .lo          (top_y),
        .hi          (bottom_y)
    );

    assign m_tdata = {4'b0000, bottom_y, right_x, top_y, left_x};

endmodule

`default_nettype wire

### rtl/abod_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module abod_cfg
    import abod_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CENTER_VAR:  cfg_next.center_var  = cfg_data[VAR_W-1:0];
                CFG_SIZE_VAR:    cfg_next.size_var    = cfg_data[VAR_W-1:0];
                CFG_IMAGE_SCALE: cfg_next.image_scale = cfg_data[SCALE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_var  <= CENTER_VAR_RESET;
            cfg_reg.size_var    <= SIZE_VAR_RESET;
            cfg_reg.image_scale <= IMAGE_SCALE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/abod_center.sv
`timescale 1ns / 1ps
`default_nettype none

module abod_center
    import abod_pkg::*;
(
    input  wire logic                           aclk,
    input  wire stage_en_t                      en,
    input  wire logic signed [OFFSET_WIDTH-1:0] offset,
    input  wire logic [PRIOR_W-1:0]             prior_c,
    input  wire logic [PRIOR_W-1:0]             prior_s,
    input  wire logic [VAR_W-1:0]               center_var,
    output logic signed [C_W-1:0]               center
);

    logic signed [CT_W-1:0] t_reg;
    logic signed [CT_W-1:0] t_next;
    logic [PRIOR_W-1:0]     pc1_reg;
    logic [PRIOR_W-1:0]     ps1_reg;
    logic signed [CP_W-1:0] p_reg;
    logic signed [CP_W-1:0] p_next;
    logic [PRIOR_W-1:0]     pc2_reg;
    logic signed [C_W-1:0]  c_reg;
    logic signed [C_W-1:0]  c_next;

    // Q28 product, then Q20 times prior size
    assign t_next = offset * $signed({1'b0, center_var});
    assign p_next = $signed(t_reg[CT_W-1:8]) * $signed({1'b0, ps1_reg});
    assign c_next = $signed({{(C_W-PRIOR_W-4){1'b0}}, pc2_reg, 4'b0000})
                  + $signed({{(C_W-CS_W){p_reg[CP_W-1]}}, p_reg[CP_W-1:16]});

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t_reg   <= t_next;
            pc1_reg <= prior_c;
            ps1_reg <= prior_s;
        end
        if (en[1]) begin
            p_reg   <= p_next;
            pc2_reg <= pc1_reg;
        end
        if (en[2]) begin
            c_reg   <= c_next;
        end
    end

    assign center = c_reg;

endmodule

`default_nettype wire

### rtl/abod_half.sv
`timescale 1ns / 1ps
`default_nettype none

module abod_half
    import abod_pkg::*;
(
    input  wire logic                           aclk,
    input  wire stage_en_t                      en,
    input  wire logic signed [OFFSET_WIDTH-1:0] offset,
    input  wire logic [PRIOR_W-1:0]             prior_s,
    input  wire logic [VAR_W-1:0]               size_var,
    output logic [HALF_W-1:0]                   half
);

    logic signed [A_W-1:0] a_reg;
    logic signed [A_W-1:0] a_next;
    logic signed [A_W-1:0] a_clamp;
    logic [31:0]           a_biased;
    logic [EXP_IDX_W-1:0]  k;
    logic [PRIOR_W-1:0]    ps1_reg;
    logic [PRIOR_W-1:0]    ps2_reg;
    logic [EXP_W-1:0]      e_reg;
    logic [HP_W-1:0]       h_prod;
    logic [HALF_W-1:0]     h_reg;

    assign a_next = offset * $signed({1'b0, size_var});

    always_comb begin
        priority if (a_reg < EXP_ARG_LO) begin
            a_clamp = EXP_ARG_LO;
        end else if (a_reg > EXP_ARG_HI) begin
            a_clamp = EXP_ARG_HI;
        end else begin
            a_clamp = a_reg;
        end
    end

    // adding 2^31 to a value in [-2^31, 2^31) flips bit 31
    assign a_biased = {~a_clamp[31], a_clamp[30:0]};
    assign k        = a_biased[31 -: EXP_IDX_W];
    assign h_prod   = HP_W'(ps2_reg) * HP_W'(e_reg);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_reg   <= a_next;
            ps1_reg <= prior_s;
        end
        if (en[1]) begin
            e_reg   <= EXP_TABLE[k];
            ps2_reg <= ps1_reg;
        end
        if (en[2]) begin
            h_reg   <= h_prod[21 +: HALF_W];
        end
    end

    assign half = h_reg;

endmodule

`default_nettype wire

### rtl/abod_corner.sv
`timescale 1ns / 1ps
`default_nettype none

module abod_corner
    import abod_pkg::*;
(
    input  wire logic                  aclk,
    input  wire stage_en_t             en,
    input  wire logic signed [C_W-1:0] center,
    input  wire logic [HALF_W-1:0]     half,
    input  wire logic [SCALE_W-1:0]    image_scale,
    output logic [OUT_W-1:0]           lo,
    output logic [OUT_W-1:0]           hi
);

    logic signed [K_W-1:0]         c_ext;
    logic signed [K_W-1:0]         h_ext;
    logic signed [K_W-1:0]         lo_k_reg;
    logic signed [K_W-1:0]         hi_k_reg;
    logic signed [K_W+SCALE_W:0]   lo_prod;
    logic signed [K_W+SCALE_W:0]   hi_prod;
    logic signed [Q_W-1:0]         lo_q_reg;
    logic signed [Q_W-1:0]         hi_q_reg;
    logic [OUT_W-1:0]              lo_next;
    logic [OUT_W-1:0]              hi_next;
    logic [OUT_W-1:0]              lo_reg;
    logic [OUT_W-1:0]              hi_reg;

    assign c_ext = $signed({{(K_W-C_W){center[C_W-1]}}, center});
    assign h_ext = $signed({{(K_W-HALF_W){1'b0}}, half});

    assign lo_prod = lo_k_reg * $signed({1'b0, image_scale});
    assign hi_prod = hi_k_reg * $signed({1'b0, image_scale});

    function automatic logic [OUT_W-1:0] sat(input logic signed [Q_W-1:0] v);
        logic [OUT_W-1:0] r;
        priority if (v < OUT_MIN) begin
            r = OUT_MIN[OUT_W-1:0];
        end else if (v > OUT_MAX) begin
            r = OUT_MAX[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    assign lo_next = sat(lo_q_reg);
    assign hi_next = sat(hi_q_reg);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            lo_k_reg <= c_ext - h_ext;
            hi_k_reg <= c_ext + h_ext;
        end
        if (en[4]) begin
            lo_q_reg <= lo_prod[K_W+SCALE_W:16];
            hi_q_reg <= hi_prod[K_W+SCALE_W:16];
        end
        if (en[5]) begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

`default_nettype wire
